### design/csv_field_tokenizer_core_macros.svh
// assertion macros shared by the tokenizer files
`ifndef CSV_FIELD_TOKENIZER_CORE_MACROS_SVH
`define CSV_FIELD_TOKENIZER_CORE_MACROS_SVH

// condition holds at every rising clock edge out of reset
`define CSVFT_CHECK(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("csvft check failed");

// same-cycle implication
`define CSVFT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csvft implication failed");

// next-cycle implication
`define CSVFT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("csvft next-cycle check failed");

`endif

### design/csvft_pkg.sv
package csvft_pkg;

	localparam int MAX_FIELDS = 256;
	localparam int FI_W = $clog2(MAX_FIELDS + 1);
	localparam logic [FI_W-1:0] FIELD_LIMIT = FI_W'(MAX_FIELDS - 1);

	localparam int MAX_RES = 3;
	localparam int NRES_W = $clog2(MAX_RES + 1);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_END = 1'b1;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_FEND = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;
	localparam logic [1:0] KIND_EOT = 2'd3;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_QUOTE = 2'd1;
	localparam logic [1:0] ERR_WIDTH = 2'd2;
	localparam logic [1:0] ERR_FIELDS = 2'd3;

	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] field_byte;
		logic [7:0] column;
		logic in_header;
		logic row_end;
		logic [1:0] error_code;
		logic last;
	} res_t;

	typedef res_t [MAX_RES-1:0] res_vec_t;

endpackage

### design/csv_field_tokenizer_core.sv
// csv field tokenizer
// input channel: in_valid/in_ready with action and text_byte; action 0 carries one
// byte of csv text, action 1 marks end of text and returns the tokenizer state to reset
// output channel: out_valid/out_ready, one result per transaction (kind, field_byte,
// column, in_header, row_end, error_code, last); an input byte gives zero to three
// results, the final one flagged by last
// results of an accepted byte are written into the result queue at the edge that accepts it
// throughput: one input byte per cycle while each byte gives at most one result and out_ready
// stays high; a byte giving two or three results holds in_ready low until the four-entry
// result queue drains back to one entry, so the output port (one result per cycle) sets the rate
// in_ready is high when the result queue holds at most one entry
// reset: the queue empties and the tokenizer starts a fresh text with no header
// receiver stall: results wait in the queue; once it fills past one entry in_ready
// drops, and no result is lost or reordered
module csv_field_tokenizer_core
	import csvft_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic action,
	input  logic [7:0] text_byte,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] kind,
	output logic [7:0] field_byte,
	output logic [7:0] column,
	output logic in_header,
	output logic row_end,
	output logic [1:0] error_code,
	output logic last
);

	logic in_acc;
	logic pop;
	logic [NRES_W-1:0] res_n;
	res_vec_t res;
	res_t head;
	logic [FIFO_CNT_W-1:0] count;

	assign in_ready = count <= FIFO_CNT_W'(1);
	assign in_acc = in_valid && in_ready;
	assign out_valid = count != '0;
	assign pop = out_valid && out_ready;

	csvft_tokenizer u_tok (
		.clk(clk),
		.arst_n(arst_n),
		.accept(in_acc),
		.action(action),
		.text_byte(text_byte),
		.res_n(res_n),
		.res(res)
	);

	csvft_res_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_n(res_n),
		.push_data(res),
		.pop(pop),
		.head(head),
		.count(count)
	);

	assign kind = head.kind;
	assign field_byte = head.field_byte;
	assign column = head.column;
	assign in_header = head.in_header;
	assign row_end = head.row_end;
	assign error_code = head.error_code;
	assign last = head.last;

endmodule

### design/csvft_tokenizer.sv
`include "csv_field_tokenizer_core_macros.svh"

module csvft_tokenizer
	import csvft_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic action,
	input  logic [7:0] text_byte,
	output logic [NRES_W-1:0] res_n,
	output res_vec_t res
);

	typedef struct packed {
		logic in_quotes;
		logic quote_pending;
		logic cr_pending;
		logic line_started;
		logic [FI_W-1:0] field_index;
		logic [FI_W-1:0] header_width;
		logic header_seen;
		logic halted;
	} st_t;

	typedef struct packed {
		st_t st;
		logic [NRES_W-1:0] n;
		res_vec_t res;
	} tk_t;

	st_t st_q;
	tk_t tk;

	function automatic tk_t emit(tk_t t, logic [1:0] k, logic [7:0] fb, logic [7:0] col,
		logic hdr, logic rend, logic [1:0] err);
		tk_t r;
		r = t;
		if (r.n < NRES_W'(MAX_RES)) begin
			r.res[r.n] = '{k, fb, col, hdr, rend, err, 1'b0};
			r.n = r.n + NRES_W'(1);
		end
		return r;
	endfunction

	function automatic tk_t emit_here(tk_t t, logic [1:0] k, logic [7:0] fb, logic rend,
		logic [1:0] err);
		return emit(t, k, fb, 8'(t.st.field_index), !t.st.header_seen, rend, err);
	endfunction

	function automatic tk_t clear_line(tk_t t);
		tk_t r;
		r = t;
		r.st.in_quotes = 1'b0;
		r.st.quote_pending = 1'b0;
		r.st.cr_pending = 1'b0;
		r.st.line_started = 1'b0;
		r.st.field_index = '0;
		return r;
	endfunction

	function automatic tk_t raise_error(tk_t t, logic [1:0] code);
		tk_t r;
		r = emit_here(t, KIND_ERR, 8'h00, 1'b0, code);
		r = clear_line(r);
		r.st.halted = 1'b1;
		return r;
	endfunction

	function automatic tk_t end_line(tk_t t);
		tk_t r;
		r = t;
		if (r.st.quote_pending) begin
			r.st.quote_pending = 1'b0;
			r.st.in_quotes = 1'b0;
		end
		r.st.cr_pending = 1'b0;
		if (r.st.header_seen && !r.st.line_started) begin
			r = clear_line(r);
		end else if (r.st.in_quotes) begin
			r = raise_error(r, ERR_QUOTE);
		end else begin
			r = emit_here(r, KIND_FEND, 8'h00, 1'b1, ERR_NONE);
			if (!r.st.header_seen) begin
				r.st.header_width = r.st.field_index + FI_W'(1);
				r.st.header_seen = 1'b1;
				r = clear_line(r);
			end else if (r.st.field_index + FI_W'(1) != r.st.header_width) begin
				r = raise_error(r, ERR_WIDTH);
			end else begin
				r = clear_line(r);
			end
		end
		return r;
	endfunction

	function automatic tk_t plain_byte(tk_t t, logic [7:0] b);
		tk_t r;
		r = t;
		if (b == CH_LF) begin
			r = end_line(r);
		end else if (b == CH_CR) begin
			r.st.cr_pending = 1'b1;
		end else begin
			r.st.line_started = 1'b1;
			if (b == CH_QUOTE) begin
				if (r.st.in_quotes) begin
					r.st.quote_pending = 1'b1;
				end else begin
					r.st.in_quotes = 1'b1;
				end
			end else if (b == CH_COMMA && !r.st.in_quotes) begin
				if (r.st.field_index >= FIELD_LIMIT) begin
					r = raise_error(r, ERR_FIELDS);
				end else begin
					r = emit_here(r, KIND_FEND, 8'h00, 1'b0, ERR_NONE);
					r.st.field_index = r.st.field_index + FI_W'(1);
				end
			end else begin
				r = emit_here(r, KIND_BYTE, b, 1'b0, ERR_NONE);
			end
		end
		return r;
	endfunction

	always_comb begin
		tk.st = st_q;
		tk.n = '0;
		tk.res = '0;
		if (action == ACT_END) begin
			if (!st_q.halted && (st_q.header_seen ? st_q.line_started
				: (st_q.line_started || st_q.cr_pending))) begin
				tk = end_line(tk);
			end
			tk = emit(tk, KIND_EOT, 8'h00, 8'h00, 1'b0, 1'b0, ERR_NONE);
			tk.st = '0;
		end else if (!st_q.halted) begin
			if (st_q.cr_pending) begin
				tk.st.cr_pending = 1'b0;
				if (text_byte == CH_LF) begin
					tk = end_line(tk);
				end else begin
					tk.st.line_started = 1'b1;
					tk = emit_here(tk, KIND_BYTE, CH_CR, 1'b0, ERR_NONE);
					tk = plain_byte(tk, text_byte);
				end
			end else if (st_q.quote_pending) begin
				tk.st.quote_pending = 1'b0;
				if (text_byte == CH_QUOTE) begin
					tk = emit_here(tk, KIND_BYTE, CH_QUOTE, 1'b0, ERR_NONE);
				end else begin
					tk.st.in_quotes = 1'b0;
					tk = plain_byte(tk, text_byte);
				end
			end else begin
				tk = plain_byte(tk, text_byte);
			end
		end
		if (tk.n != '0) begin
			tk.res[tk.n - NRES_W'(1)].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (accept) begin
			st_q <= tk.st;
		end
	end

	assign res_n = accept ? tk.n : '0;
	assign res = tk.res;

	`CSVFT_IMPLY(a_eot_gives_result, accept && action == ACT_END, res_n != '0)
	`CSVFT_NEXT(a_eot_clears_state, accept && action == ACT_END, st_q == '0)
	`CSVFT_IMPLY(a_halted_silent, accept && action == ACT_BYTE && st_q.halted, res_n == '0)

endmodule

### design/csvft_res_fifo.sv
`include "csv_field_tokenizer_core_macros.svh"

module csvft_res_fifo
	import csvft_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic [NRES_W-1:0] push_n,
	input  res_vec_t push_data,
	input  logic pop,
	output res_t head,
	output logic [FIFO_CNT_W-1:0] count
);

	res_t mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (NRES_W'(i) < push_n) begin
				mem_q[wr_q + FIFO_PTR_W'(i)] <= push_data[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + FIFO_PTR_W'(push_n);
			rd_q <= rd_q + FIFO_PTR_W'(pop);
			cnt_q <= cnt_q + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
		end
	end

	assign head = mem_q[rd_q];
	assign count = cnt_q;

	`CSVFT_CHECK(a_cnt_range, cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
	`CSVFT_IMPLY(a_no_overflow, push_n != '0,
		cnt_q + FIFO_CNT_W'(push_n) <= FIFO_CNT_W'(FIFO_DEPTH) + FIFO_CNT_W'(pop))
	`CSVFT_IMPLY(a_no_underflow, pop, cnt_q != '0)

endmodule

### sim/tb_csv_field_tokenizer_core.sv
`timescale 1ns / 100ps

module tb_csv_field_tokenizer_core;
	import csvft_pkg::*;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = ACT_BYTE;
	logic [7:0] text_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] field_byte;
	logic [7:0] column;
	logic in_header;
	logic row_end;
	logic [1:0] error_code;
	logic last;

	logic steady = 1'b0;
	logic hold_rx = 1'b0;

	int fail_count = 0;
	int items_sent = 0;
	int results_checked = 0;
	int random_texts = 0;

	// tokenizer state as predicted
	logic tk_in_quotes;
	logic tk_quote_pend;
	logic tk_cr_pend;
	logic tk_line_started;
	logic tk_header_seen;
	logic tk_halted;
	logic [FI_W-1:0] tk_field_idx;
	logic [FI_W-1:0] tk_header_width;

	res_t item_tokens[$];
	res_t expected_tokens[$];

	csv_field_tokenizer_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.text_byte(text_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.field_byte(field_byte),
		.column(column),
		.in_header(in_header),
		.row_end(row_end),
		.error_code(error_code),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void tok_push(logic [1:0] k, logic [7:0] b, logic [7:0] col,
			logic hdr, logic rend, logic [1:0] err);
		res_t r;
		if (item_tokens.size() >= MAX_RES)
			return;
		r.kind = k;
		r.field_byte = b;
		r.column = col;
		r.in_header = hdr;
		r.row_end = rend;
		r.error_code = err;
		r.last = 1'b0;
		item_tokens.insert(item_tokens.size(), r);
	endfunction

	function automatic void tok_emit(logic [1:0] k, logic [7:0] b, logic [1:0] err, logic rend);
		tok_push(k, b, 8'(tk_field_idx), !tk_header_seen, rend, err);
	endfunction

	function automatic void tok_clear_line();
		tk_in_quotes = 1'b0;
		tk_quote_pend = 1'b0;
		tk_cr_pend = 1'b0;
		tk_line_started = 1'b0;
		tk_field_idx = '0;
	endfunction

	function automatic void tok_reset();
		tok_clear_line();
		tk_header_width = '0;
		tk_header_seen = 1'b0;
		tk_halted = 1'b0;
	endfunction

	function automatic void tok_raise(logic [1:0] code);
		tok_emit(KIND_ERR, 8'h00, code, 1'b0);
		tok_clear_line();
		tk_halted = 1'b1;
	endfunction

	function automatic void tok_end_line();
		if (tk_quote_pend) begin
			tk_quote_pend = 1'b0;
			tk_in_quotes = 1'b0;
		end
		tk_cr_pend = 1'b0;
		if (tk_header_seen && !tk_line_started) begin
			tok_clear_line();
			return;
		end
		if (tk_in_quotes) begin
			tok_raise(ERR_QUOTE);
			return;
		end
		tok_emit(KIND_FEND, 8'h00, ERR_NONE, 1'b1);
		if (!tk_header_seen) begin
			tk_header_width = tk_field_idx + 1'b1;
			tk_header_seen = 1'b1;
		end else if (tk_field_idx + 1'b1 != tk_header_width) begin
			tok_raise(ERR_WIDTH);
			return;
		end
		tok_clear_line();
	endfunction

	function automatic void tok_plain(logic [7:0] b);
		if (b == CH_LF) begin
			tok_end_line();
			return;
		end
		if (b == CH_CR) begin
			tk_cr_pend = 1'b1;
			return;
		end
		tk_line_started = 1'b1;
		if (b == CH_QUOTE) begin
			if (tk_in_quotes)
				tk_quote_pend = 1'b1;
			else
				tk_in_quotes = 1'b1;
		end else if (b == CH_COMMA && !tk_in_quotes) begin
			if (int'(tk_field_idx) + 1 >= MAX_FIELDS) begin
				tok_raise(ERR_FIELDS);
				return;
			end
			tok_emit(KIND_FEND, 8'h00, ERR_NONE, 1'b0);
			tk_field_idx = tk_field_idx + 1'b1;
		end else begin
			tok_emit(KIND_BYTE, b, ERR_NONE, 1'b0);
		end
	endfunction

	function automatic void tokenize_item(logic act, logic [7:0] b);
		item_tokens.delete();
		if (act == ACT_END) begin
			if (!tk_halted && (tk_header_seen ? tk_line_started : (tk_line_started || tk_cr_pend)))
				tok_end_line();
			tok_push(KIND_EOT, 8'h00, 8'h00, 1'b0, 1'b0, ERR_NONE);
			tok_reset();
		end else if (!tk_halted) begin
			if (tk_cr_pend) begin
				tk_cr_pend = 1'b0;
				if (b == CH_LF) begin
					tok_end_line();
				end else begin
					tk_line_started = 1'b1;
					tok_emit(KIND_BYTE, CH_CR, ERR_NONE, 1'b0);
					tok_plain(b);
				end
			end else if (tk_quote_pend) begin
				tk_quote_pend = 1'b0;
				if (b == CH_QUOTE) begin
					tok_emit(KIND_BYTE, CH_QUOTE, ERR_NONE, 1'b0);
				end else begin
					tk_in_quotes = 1'b0;
					tok_plain(b);
				end
			end else begin
				tok_plain(b);
			end
		end
		if (item_tokens.size() > 0)
			item_tokens[item_tokens.size() - 1].last = 1'b1;
		foreach (item_tokens[i])
			expected_tokens.insert(expected_tokens.size(), item_tokens[i]);
	endfunction

	task automatic report_mismatch(input string what, input int want_v, input int got_v);
		$display("mismatch on %s: expected 'h%0h, got 'h%0h at %0t", what, want_v, got_v, $time);
		fail_count++;
	endtask

	always @(posedge clk) begin : result_check
		res_t got;
		res_t want;
		if (arst_n && in_valid && in_ready)
			tokenize_item(action, text_byte);
		if (arst_n && out_valid && out_ready) begin
			got.kind = kind;
			got.field_byte = field_byte;
			got.column = column;
			got.in_header = in_header;
			got.row_end = row_end;
			got.error_code = error_code;
			got.last = last;
			results_checked++;
			if (expected_tokens.size() == 0) begin
				report_mismatch("unexpected result, kind", 0, got.kind);
			end else begin
				want = expected_tokens.pop_front();
				if (got.kind !== want.kind)
					report_mismatch("kind", want.kind, got.kind);
				if (got.field_byte !== want.field_byte)
					report_mismatch("field_byte", want.field_byte, got.field_byte);
				if (got.column !== want.column)
					report_mismatch("column", want.column, got.column);
				if (got.in_header !== want.in_header)
					report_mismatch("in_header", want.in_header, got.in_header);
				if (got.row_end !== want.row_end)
					report_mismatch("row_end", want.row_end, got.row_end);
				if (got.error_code !== want.error_code)
					report_mismatch("error_code", want.error_code, got.error_code);
				if (got.last !== want.last)
					report_mismatch("last", want.last, got.last);
			end
		end
	end

	// receiver: random idling unless held off or in a steady stretch
	initial begin
		forever begin
			@(posedge clk);
			if (hold_rx)
				out_ready <= 1'b0;
			else if (steady)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(99) >= 18);
		end
	end

	task automatic send_item(input logic act, input logic [7:0] b);
		while (!steady && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		text_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(ACT_BYTE, b);
	endtask

	task automatic send_eot();
		send_item(ACT_END, 8'($urandom_range(255)));
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_tokens.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_text();
		send_item(ACT_END, 8'hff);
		drain();
	endtask

	task automatic test_quotes_and_cr();
		send_string("a,\"b\"\"c\"\015\012");
		// held cr before an ordinary byte, then byte extremes
		send_string("\015q,");
		send_byte(8'hff);
		send_byte(8'h00);
		send_string("\012\012r,s\015");
		send_eot();
		drain();
	endtask

	task automatic test_empty_header();
		send_byte(CH_LF);
		send_string("a,b\012zz\012");
		send_eot();
		drain();
	endtask

	task automatic test_open_quote();
		send_string("h\"1,2\"\012\"ab\012x");
		send_eot();
		drain();
	endtask

	task automatic test_output_backpressure();
		fork
			begin
				hold_rx <= 1'b1;
				repeat (80) @(posedge clk);
				hold_rx <= 1'b0;
			end
			send_string("ab,cd,ef\012gh,ij,kl\012");
		join
		send_eot();
		drain();
	endtask

	task automatic test_random_texts();
		int start;
		int ncols;
		int nlines;
		int width;
		int len;
		logic [7:0] b;
		logic quoted;
		start = items_sent;
		while (items_sent - start < 60) begin
			steady <= (items_sent - start < 25);
			ncols = $urandom_range(1, 4);
			nlines = $urandom_range(1, 5);
			for (int ln = 0; ln < nlines; ln++) begin
				if (ln > 0 && $urandom_range(9) == 0) begin
					send_byte(CH_LF);
				end else begin
					width = ncols;
					if ($urandom_range(9) == 0)
						width = (ncols > 1 && $urandom_range(1) == 1) ? ncols - 1 : ncols + 1;
					for (int f = 0; f < width; f++) begin
						if (f > 0)
							send_byte(CH_COMMA);
						quoted = ($urandom_range(2) == 0);
						if (quoted)
							send_byte(CH_QUOTE);
						len = $urandom_range(0, 3);
						for (int k = 0; k < len; k++) begin
							b = 8'($urandom_range(255));
							if (quoted) begin
								if (b == CH_LF)
									b ^= 8'h40;
								if (b == CH_QUOTE)
									send_byte(b);
							end else if (b == CH_COMMA || b == CH_QUOTE || b == CH_CR || b == CH_LF) begin
								b ^= 8'h40;
							end
							send_byte(b);
						end
						if (quoted && $urandom_range(19) != 0)
							send_byte(CH_QUOTE);
					end
					if (ln < nlines - 1 || $urandom_range(3) != 0) begin
						if ($urandom_range(1) == 1)
							send_byte(CH_CR);
						send_byte(CH_LF);
					end
				end
			end
			// raw noise before end of text
			if ($urandom_range(5) == 0)
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
			send_eot();
			random_texts++;
		end
		steady <= 1'b0;
		drain();
	endtask

	initial begin
		#400000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		tok_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_text();
		test_quotes_and_cr();
		test_empty_header();
		test_open_quote();
		test_output_backpressure();
		test_random_texts();
		repeat (10) @(posedge clk);
		$display("%0d input transactions (%0d random texts), %0d results checked",
			items_sent, random_texts, results_checked);
		$display("covered quoting, cr handling, empty header, quote and width errors, output stall");
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
